// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the register file rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_SYNC(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_SYNC(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== rtl/core/fmrf_pkg.sv =====
// shared types, register codes and fixed tables of the fm register file
// no dependencies
package fmrf_pkg;

   localparam int NUM_CHANNELS = 9;
   localparam int NUM_SLOTS    = 18;
   localparam int CHAN_AW      = $clog2(NUM_CHANNELS);
   localparam int PARAM_W      = 36;

   // register address decode
   localparam logic [5:0] ADDR_RHYTHM  = 6'h0E;
   localparam logic [1:0] GRP_FREQ_LO  = 2'd1;
   localparam logic [1:0] GRP_FREQ_HI  = 2'd2;
   localparam logic [1:0] GRP_INST_VOL = 2'd3;

   // offset added to a drum slot number to give its row of the fixed patch table
   localparam logic [5:0] DRUM_ROW_OFFSET = 6'd20;

   // one channel entry of the channel memory
   typedef struct packed {
      logic [3:0]  inst;
      logic [3:0]  vol;
      logic        sus;
      logic        key;
      logic [11:0] freq;
   } chan_type;

   // write lanes of a channel entry
   typedef struct packed {
      logic lo;
      logic hi;
      logic iv;
   } lane_type;

   // slot query travelling from the read stage to the level stage
   typedef struct packed {
      logic               valid;
      logic [4:0]         slot;
      logic               in_range;
      logic               chan_valid;
      logic [5:0]         rhythm;
      logic [PARAM_W-1:0] user;
   } query_type;

   function automatic logic [PARAM_W-1:0] patch_pack(
      input int am, input int pm, input int eg, input int kr, input int ml,
      input int kl, input int tl, input int wf, input int fb, input int ar,
      input int dr, input int sl, input int rr);
      return {am[0], pm[0], eg[0], kr[0], ml[3:0], kl[1:0], tl[5:0], wf[0],
              fb[2:0], ar[3:0], dr[3:0], sl[3:0], rr[3:0]};
   endfunction

   // fixed instrument and drum patches; rows below two are unused
   function automatic logic [PARAM_W-1:0] rom_patch(input logic [5:0] row);
      logic [PARAM_W-1:0] p;
      case (row)
         6'd2:  p = patch_pack(0,1,1,0,1,0,'h1e,0,7,15, 0, 0, 0);
         6'd3:  p = patch_pack(0,1,1,0,1,0,'h00,1,0, 7,15, 1, 7);
         6'd4:  p = patch_pack(0,0,0,1,3,0,'h17,1,6,15,15, 2, 3);
         6'd5:  p = patch_pack(0,1,0,0,1,0,'h00,0,0,15,15, 1, 3);
         6'd6:  p = patch_pack(0,0,1,0,3,2,'h1a,0,4,10, 3,15, 0);
         6'd7:  p = patch_pack(0,0,0,0,1,0,'h00,0,0,15, 4, 2, 3);
         6'd8:  p = patch_pack(0,0,0,1,1,0,'h0e,0,7,15,10, 7, 0);
         6'd9:  p = patch_pack(0,1,1,0,1,0,'h00,0,0, 6, 4, 1, 7);
         6'd10: p = patch_pack(0,0,1,0,2,0,'h1e,0,6,15, 0, 0, 0);
         6'd11: p = patch_pack(0,0,1,0,1,0,'h00,0,0, 7, 6, 2, 8);
         6'd12: p = patch_pack(0,0,1,0,1,0,'h16,0,5,15, 0, 0, 0);
         6'd13: p = patch_pack(0,0,1,0,2,0,'h00,0,0, 7, 1, 1, 8);
         6'd14: p = patch_pack(0,0,1,0,1,0,'h1d,0,7, 8, 2, 1, 0);
         6'd15: p = patch_pack(0,1,1,0,1,0,'h00,0,0, 8, 0, 0, 7);
         6'd16: p = patch_pack(0,0,1,0,3,0,'h2d,0,6, 9, 0, 0, 0);
         6'd17: p = patch_pack(0,0,1,0,1,0,'h00,1,0, 9, 0, 0, 7);
         6'd18: p = patch_pack(0,0,1,0,1,0,'h1b,0,6, 6, 4, 1, 0);
         6'd19: p = patch_pack(0,0,1,0,1,0,'h00,0,0, 6, 5, 1, 7);
         6'd20: p = patch_pack(0,0,1,0,1,0,'h0b,1,2, 8, 5, 7, 0);
         6'd21: p = patch_pack(0,0,1,0,1,0,'h00,1,0,10, 0, 0, 7);
         6'd22: p = patch_pack(0,0,1,0,3,2,'h02,0,0,15,15, 1, 0);
         6'd23: p = patch_pack(0,0,0,0,1,0,'h00,1,0,11, 0, 0, 4);
         6'd24: p = patch_pack(1,0,0,1,7,0,'h20,0,7,15,15, 2, 2);
         6'd25: p = patch_pack(1,1,0,0,1,0,'h00,0,0,15,15, 1, 2);
         6'd26: p = patch_pack(0,1,1,0,1,0,'h0c,0,5,13, 2, 4, 0);
         6'd27: p = patch_pack(0,0,0,0,0,0,'h00,0,0,15, 6, 4, 3);
         6'd28: p = patch_pack(0,0,0,0,1,1,'h16,0,3,15, 4, 0, 3);
         6'd29: p = patch_pack(0,0,0,0,1,0,'h00,0,0,15, 0, 0, 2);
         6'd30: p = patch_pack(0,0,1,0,1,2,'h09,0,3,15, 1,15, 0);
         6'd31: p = patch_pack(0,1,0,0,1,0,'h00,0,0,15, 4, 2, 3);
         6'd32: p = patch_pack(0,0,0,0,7,0,'h16,0,0,13,15,15,15);
         6'd33: p = patch_pack(0,0,1,0,1,0,'h00,0,0,15, 8,15, 8);
         6'd34: p = patch_pack(0,0,1,1,1,0,'h00,0,0,15, 7,15, 7);
         6'd35: p = patch_pack(0,0,1,1,2,0,'h00,0,0,15, 7,15, 7);
         6'd36: p = patch_pack(0,0,1,0,5,0,'h00,0,0,15, 8,15, 8);
         6'd37: p = patch_pack(0,0,0,0,1,0,'h00,0,0,13,12, 5, 5);
         default: p = '0;
      endcase
      return p;
   endfunction

   // key-scale base per top four frequency bits
   function automatic logic [5:0] ksl_base(input logic [3:0] idx);
      logic [5:0] v;
      case (idx)
         4'd0:  v = 6'h00;
         4'd1:  v = 6'h18;
         4'd2:  v = 6'h20;
         4'd3:  v = 6'h25;
         4'd4:  v = 6'h28;
         4'd5:  v = 6'h2b;
         4'd6:  v = 6'h2d;
         4'd7:  v = 6'h2f;
         4'd8:  v = 6'h30;
         4'd9:  v = 6'h32;
         4'd10: v = 6'h33;
         4'd11: v = 6'h34;
         4'd12: v = 6'h35;
         4'd13: v = 6'h36;
         4'd14: v = 6'h37;
         4'd15: v = 6'h38;
         default: v = 6'h00;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/fmrf_chan_ram.sv =====
// channel memory: nine entries with per-lane write enables, registered read
// depends on fmrf_pkg
module fmrf_chan_ram (
   input  logic                          clock,
   input  fmrf_pkg::lane_type            wr_lane,
   input  logic [fmrf_pkg::CHAN_AW-1:0]  wr_addr,
   input  fmrf_pkg::chan_type            wr_data,
   input  logic                          rd_en,
   input  logic [fmrf_pkg::CHAN_AW-1:0]  rd_addr,
   output fmrf_pkg::chan_type            rd_data
);

   fmrf_pkg::chan_type mem [fmrf_pkg::NUM_CHANNELS];
   fmrf_pkg::chan_type rd_data_ff;

   // lane writes
   always_ff @(posedge clock) begin
      if (wr_lane.lo) begin
         mem[wr_addr].freq[7:0] <= wr_data.freq[7:0];
      end
      if (wr_lane.hi) begin
         mem[wr_addr].freq[11:8] <= wr_data.freq[11:8];
         mem[wr_addr].key        <= wr_data.key;
         mem[wr_addr].sus        <= wr_data.sus;
      end
      if (wr_lane.iv) begin
         mem[wr_addr].inst <= wr_data.inst;
         mem[wr_addr].vol  <= wr_data.vol;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fmrf_level.sv =====
// level stage: patch selection, key-scale level, total level and result word
// depends on fmrf_pkg
module fmrf_level (
   input  logic                           clock,
   input  logic                           reset,
   input  fmrf_pkg::query_type            query,
   input  fmrf_pkg::chan_type             chan_raw,
   output logic                           rsp_valid,
   output logic [4:0]                     rsp_slot_echo,
   output logic [6:0]                     rsp_total_level,
   output logic [8:0]                     rsp_freq_number,
   output logic [2:0]                     rsp_octave_block,
   output logic                           rsp_key_on,
   output logic                           rsp_sustain_on,
   output logic [5:0]                     rsp_rhythm_control,
   output logic [fmrf_pkg::PARAM_W-1:0]   rsp_operator_params
);

   fmrf_pkg::chan_type            chan;
   logic                          drum;
   logic [fmrf_pkg::PARAM_W-1:0]  patch;
   logic [1:0]                    kl;
   logic [7:0]                    diff;
   logic [7:0]                    kll_raw;
   logic [7:0]                    kll;
   logic [6:0]                    base_level;
   logic [7:0]                    level_sum;
   logic [6:0]                    level_sat;

   logic                          valid_ff;
   logic [4:0]                    slot_ff;
   logic [6:0]                    level_ff;
   logic [8:0]                    fnum_ff;
   logic [2:0]                    block_ff;
   logic                          key_ff;
   logic                          sus_ff;
   logic [5:0]                    rhythm_ff;
   logic [fmrf_pkg::PARAM_W-1:0]  params_ff;

   // never-written entries read as zero
   assign chan = query.chan_valid ? chan_raw : '0;

   // patch selection
   always_comb begin
      drum = query.rhythm[5] && (query.slot >= 5'd12);
      if (drum) begin
         patch = fmrf_pkg::rom_patch({1'b0, query.slot} + fmrf_pkg::DRUM_ROW_OFFSET);
      end else if (chan.inst == 4'd0) begin
         patch = query.user;
      end else begin
         patch = fmrf_pkg::rom_patch({1'b0, chan.inst, query.slot[0]});
      end
   end

   // key-scale level
   always_comb begin
      kl      = patch[27:26];
      diff    = {2'b00, fmrf_pkg::ksl_base(chan.freq[8:5])} - {2'b00, ~chan.freq[11:9], 3'b000};
      kll_raw = {diff[6:0], 1'b0};
      kll     = '0;
      if (!diff[6]) begin
         case (kl)
            2'd1:    kll = kll_raw >> 2;
            2'd2:    kll = kll_raw >> 1;
            2'd3:    kll = kll_raw;
            default: kll = '0;
         endcase
      end
   end

   // total level, saturated
   always_comb begin
      if (query.rhythm[5] && (query.slot == 5'd14 || query.slot == 5'd16)) begin
         base_level = {chan.inst, 3'b000};
      end else if (!query.slot[0]) begin
         base_level = {patch[25:20], 1'b0};
      end else begin
         base_level = {chan.vol, 3'b000};
      end
      level_sum = {1'b0, base_level} + kll;
      level_sat = level_sum[7] ? 7'h7f : level_sum[6:0];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= query.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (query.valid) begin
         slot_ff <= query.slot;
         if (query.in_range) begin
            level_ff  <= level_sat;
            fnum_ff   <= chan.freq[8:0];
            block_ff  <= chan.freq[11:9];
            key_ff    <= chan.key;
            sus_ff    <= chan.sus;
            rhythm_ff <= query.rhythm;
            params_ff <= patch;
         end else begin
            level_ff  <= '0;
            fnum_ff   <= '0;
            block_ff  <= '0;
            key_ff    <= 1'b0;
            sus_ff    <= 1'b0;
            rhythm_ff <= '0;
            params_ff <= '0;
         end
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_slot_echo       = slot_ff;
   assign rsp_total_level     = level_ff;
   assign rsp_freq_number     = fnum_ff;
   assign rsp_octave_block    = block_ff;
   assign rsp_key_on          = key_ff;
   assign rsp_sustain_on      = sus_ff;
   assign rsp_rhythm_control  = rhythm_ff;
   assign rsp_operator_params = params_ff;

endmodule

// ===== rtl/core/fm_synth_register_file_level.sv =====
// top level of the fm register file: bus decode, patch registers, channel memory
// depends on fmrf_pkg, fmrf_chan_ram, fmrf_level and assert_macros.svh
//
// Usage
//   One input word is taken on each clock edge where start is high and busy is
//   low; busy stays low, so a word may be offered every cycle.
//   req_func = 0 is a bus write: req_port 0 latches the register address from
//   req_bus_data, req_port 1 writes req_bus_data to the latched register. A bus
//   write gives no result and takes effect for any word that follows it.
//   req_func = 1 queries one slot. Its result passes the query register (with the
//   registered memory read) and the result register, then is on the rsp_ ports,
//   marked by rsp_valid for exactly one cycle. Throughput is one word per cycle:
//   the channel memory is read once per query and written at most once per bus
//   write, and the two never share a cycle. The receiver cannot stall; every
//   result must be taken as it appears.
//   Synchronous reset clears the address latch, rhythm register, user patch
//   bytes and the channel valid flags; a channel never written reads as zero.
//   Slots above 17 return the slot number with every other field zero.
`include "assert_macros.svh"

module fm_synth_register_file_level (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_func,
   input  logic                           req_port,
   input  logic [7:0]                     req_bus_data,
   input  logic [4:0]                     req_slot_number,
   output logic                           rsp_valid,
   output logic [4:0]                     rsp_slot_echo,
   output logic [6:0]                     rsp_total_level,
   output logic [8:0]                     rsp_freq_number,
   output logic [2:0]                     rsp_octave_block,
   output logic                           rsp_key_on,
   output logic                           rsp_sustain_on,
   output logic [5:0]                     rsp_rhythm_control,
   output logic [fmrf_pkg::PARAM_W-1:0]   rsp_operator_params
);

   logic                                accept;
   logic                                bus_write;
   logic                                data_write;
   logic                                query_accept;
   logic                                slot_in_range;
   logic [fmrf_pkg::CHAN_AW-1:0]        rd_addr;

   logic [5:0]                          addr_ff;
   logic [5:0]                          addr_in;
   logic [5:0]                          rhythm_ff;
   logic [5:0]                          rhythm_in;
   logic [7:0]                          user_ff [8];
   logic [fmrf_pkg::NUM_CHANNELS-1:0]   chan_valid_ff;
   logic [fmrf_pkg::NUM_CHANNELS-1:0]   chan_valid_in;
   fmrf_pkg::query_type                 query_ff;
   fmrf_pkg::query_type                 query_in;

   logic [1:0]                          grp;
   logic [3:0]                          low;
   logic [fmrf_pkg::CHAN_AW-1:0]        wr_chan;
   fmrf_pkg::lane_type                  lane_sel;
   fmrf_pkg::lane_type                  wr_lane;
   fmrf_pkg::chan_type                  wr_data;
   fmrf_pkg::chan_type                  rd_data;

   logic [7:0]                          user_c;
   logic [fmrf_pkg::PARAM_W-1:0]        user_patch;

   // no stall source: every offered word is taken
   assign busy         = 1'b0;
   assign accept       = start && !busy;
   assign bus_write    = accept && !req_func;
   assign data_write   = bus_write && req_port;
   assign query_accept = accept && req_func;

   // register address decode
   always_comb begin
      grp      = addr_ff[5:4];
      low      = addr_ff[3:0];
      wr_chan  = (low >= 4'd9) ? low - 4'd9 : low;
      lane_sel = '0;
      if (addr_ff[5:3] != 3'd0 && addr_ff != fmrf_pkg::ADDR_RHYTHM) begin
         case (grp)
            fmrf_pkg::GRP_FREQ_LO:  lane_sel.lo = 1'b1;
            fmrf_pkg::GRP_FREQ_HI:  lane_sel.hi = 1'b1;
            fmrf_pkg::GRP_INST_VOL: lane_sel.iv = 1'b1;
            default:                lane_sel    = '0;
         endcase
      end
   end

   // channel write word; a first write to an entry fills the other lanes with zero
   always_comb begin
      wr_data = '0;
      if (lane_sel.lo) begin
         wr_data.freq[7:0] = req_bus_data;
      end
      if (lane_sel.hi) begin
         wr_data.freq[11:8] = req_bus_data[3:0];
         wr_data.key        = req_bus_data[4];
         wr_data.sus        = req_bus_data[5];
      end
      if (lane_sel.iv) begin
         wr_data.inst = req_bus_data[7:4];
         wr_data.vol  = req_bus_data[3:0];
      end
      wr_lane = '0;
      if (data_write && lane_sel != '0) begin
         wr_lane = chan_valid_ff[wr_chan] ? lane_sel : '1;
      end
   end

   // address latch, rhythm register and channel valid flags
   always_comb begin
      addr_in       = addr_ff;
      rhythm_in     = rhythm_ff;
      chan_valid_in = chan_valid_ff;
      if (bus_write && !req_port) begin
         addr_in = req_bus_data[5:0];
      end
      if (data_write && addr_ff == fmrf_pkg::ADDR_RHYTHM) begin
         rhythm_in = req_bus_data[5:0];
      end
      if (wr_lane != '0) begin
         chan_valid_in[wr_chan] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         rhythm_ff     <= '0;
         chan_valid_ff <= '0;
      end else begin
         addr_ff       <= addr_in;
         rhythm_ff     <= rhythm_in;
         chan_valid_ff <= chan_valid_in;
      end
   end

   // user patch bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            user_ff[i] <= '0;
         end
      end else if (data_write && addr_ff[5:3] == 3'd0) begin
         user_ff[addr_ff[2:0]] <= req_bus_data;
      end
   end

   // user patch of the queried operator
   always_comb begin
      user_c = user_ff[{2'b00, req_slot_number[0]}];
      if (req_slot_number[0]) begin
         user_patch = {user_c, user_ff[3][7:6], 6'd0, user_ff[3][4], 3'd0,
                       user_ff[5], user_ff[7]};
      end else begin
         user_patch = {user_c, user_ff[2], user_ff[3][3:0], user_ff[4], user_ff[6]};
      end
   end

   // query read stage: channel memory read plus snapshot of the patch registers
   always_comb begin
      slot_in_range       = req_slot_number < 5'(fmrf_pkg::NUM_SLOTS);
      rd_addr             = slot_in_range ? req_slot_number[4:1] : '0;
      query_in.valid      = query_accept;
      query_in.slot       = req_slot_number;
      query_in.in_range   = slot_in_range;
      query_in.chan_valid = chan_valid_ff[rd_addr];
      query_in.rhythm     = rhythm_ff;
      query_in.user       = user_patch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff <= '0;
      end else begin
         query_ff <= query_in;
      end
   end

   fmrf_chan_ram u_chan_ram (
      .clock   (clock),
      .wr_lane (wr_lane),
      .wr_addr (wr_chan),
      .wr_data (wr_data),
      .rd_en   (query_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fmrf_level u_level (
      .clock               (clock),
      .reset               (reset),
      .query               (query_ff),
      .chan_raw            (rd_data),
      .rsp_valid           (rsp_valid),
      .rsp_slot_echo       (rsp_slot_echo),
      .rsp_total_level     (rsp_total_level),
      .rsp_freq_number     (rsp_freq_number),
      .rsp_octave_block    (rsp_octave_block),
      .rsp_key_on          (rsp_key_on),
      .rsp_sustain_on      (rsp_sustain_on),
      .rsp_rhythm_control  (rsp_rhythm_control),
      .rsp_operator_params (rsp_operator_params)
   );

   // every result comes from a query that passed the query register and the result register
   `ASSERT_SYNC(a_rsp_from_query, clock, reset, rsp_valid |-> $past(query_accept, 2))
   // result carries the slot of that query
   `ASSERT_SYNC(a_rsp_slot_echo, clock, reset,
                rsp_valid |-> rsp_slot_echo == $past(req_slot_number, 2))
   // an out-of-range slot gives an all-zero result body
   `ASSERT_NEVER(a_oor_zero, clock, reset, rsp_valid && rsp_slot_echo >= 5'd18 &&
                 (rsp_total_level != 7'd0 || rsp_operator_params != '0))
   // a channel write never targets an entry beyond the last channel
   `ASSERT_NEVER(a_wr_chan_range, clock, reset, wr_lane != '0 && wr_chan >= 4'd9)

endmodule

// ===== tb/sv/tb_fm_synth_register_file_level.sv =====
// self-checking testbench for the fm register file and slot level block
// depends on fmrf_pkg and the fm_synth_register_file_level rtl
// directed table first, then random register writes and slot queries against a predictor
module tb_fm_synth_register_file_level;
   timeunit 1ns;
   timeprecision 1ps;

   // word codes
   localparam bit FUNC_BUS_WRITE  = 1'b0;
   localparam bit FUNC_SLOT_QUERY = 1'b1;
   localparam bit PORT_ADDRESS    = 1'b0;
   localparam bit PORT_DATA       = 1'b1;
   localparam bit [1:0] GRP_PATCH = 2'd0;
   localparam int USER_PATCH_COUNT = 8;

   localparam int WATCHDOG_CYCLES = 2000;
   localparam int PHASE_WORDS     = 150;
   localparam int DRAIN_CYCLES    = 100;

   // key-scale base per top four frequency bits, index 15 leftmost
   localparam bit [15:0][5:0] KSL_STEPS = {
      6'h38, 6'h37, 6'h36, 6'h35, 6'h34, 6'h33, 6'h32, 6'h30,
      6'h2f, 6'h2d, 6'h2b, 6'h28, 6'h25, 6'h20, 6'h18, 6'h00};

   // operator fields in the packed order of the result port
   typedef struct packed {
      bit       am;
      bit       pm;
      bit       eg;
      bit       kr;
      bit [3:0] ml;
      bit [1:0] kl;
      bit [5:0] tl;
      bit       wf;
      bit [2:0] fb;
      bit [3:0] ar;
      bit [3:0] dr;
      bit [3:0] sl;
      bit [3:0] rr;
   } patch_fields_type;

   typedef struct packed {
      bit [4:0]  slot_echo;
      bit [6:0]  total_level;
      bit [8:0]  freq_number;
      bit [2:0]  octave_block;
      bit        key_on;
      bit        sustain_on;
      bit [5:0]  rhythm_control;
      bit [35:0] operator_params;
   } slot_level_type;

   typedef struct packed {
      bit       func;
      bit       port;
      bit [7:0] data;
      bit [4:0] slot_number;
   } req_word_type;

   typedef struct packed {
      req_word_type   word;
      bit             known;
      slot_level_type level;
   } directed_row_type;

   // dut connections
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = 1'b0;
   logic req_port = 1'b0;
   logic [7:0] req_bus_data = '0;
   logic [4:0] req_slot_number = '0;
   logic rsp_valid;
   logic [4:0] rsp_slot_echo;
   logic [6:0] rsp_total_level;
   logic [8:0] rsp_freq_number;
   logic [2:0] rsp_octave_block;
   logic rsp_key_on;
   logic rsp_sustain_on;
   logic [5:0] rsp_rhythm_control;
   logic [fmrf_pkg::PARAM_W-1:0] rsp_operator_params;

   // predictor copy of the register file
   bit [7:0]  addr_latch;
   bit [11:0] chan_freq [fmrf_pkg::NUM_CHANNELS];
   bit        chan_key [fmrf_pkg::NUM_CHANNELS];
   bit        chan_sus [fmrf_pkg::NUM_CHANNELS];
   bit [3:0]  chan_inst [fmrf_pkg::NUM_CHANNELS];
   bit [3:0]  chan_vol [fmrf_pkg::NUM_CHANNELS];
   bit [7:0]  rhythm_reg;
   bit [7:0]  patch_bytes [USER_PATCH_COUNT];

   slot_level_type pending_levels [$];
   int mismatch_count = 0;
   int sender_idle_pct = 0;
   int quiet_cycles = 0;

   fm_synth_register_file_level DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_port            (req_port),
      .req_bus_data        (req_bus_data),
      .req_slot_number     (req_slot_number),
      .rsp_valid           (rsp_valid),
      .rsp_slot_echo       (rsp_slot_echo),
      .rsp_total_level     (rsp_total_level),
      .rsp_freq_number     (rsp_freq_number),
      .rsp_octave_block    (rsp_octave_block),
      .rsp_key_on          (rsp_key_on),
      .rsp_sustain_on      (rsp_sustain_on),
      .rsp_rhythm_control  (rsp_rhythm_control),
      .rsp_operator_params (rsp_operator_params)
   );

   always #5 clock = ~clock;

   function automatic patch_fields_type make_patch(int am, int pm, int eg, int kr, int ml,
                                                   int kl, int tl, int wf, int fb, int ar,
                                                   int dr, int sl, int rr);
      patch_fields_type p;
      p.am = am[0]; p.pm = pm[0]; p.eg = eg[0]; p.kr = kr[0];
      p.ml = 4'(ml); p.kl = 2'(kl); p.tl = 6'(tl); p.wf = wf[0];
      p.fb = 3'(fb); p.ar = 4'(ar); p.dr = 4'(dr); p.sl = 4'(sl); p.rr = 4'(rr);
      return p;
   endfunction

   // built-in instruments (rows 2-31) and drums (rows 32-37)
   function automatic patch_fields_type fixed_patch(int row);
      patch_fields_type p;
      case (row)
         2:  p = make_patch(0,1,1,0,1,0,'h1e,0,7,15, 0, 0, 0);
         3:  p = make_patch(0,1,1,0,1,0,'h00,1,0, 7,15, 1, 7);
         4:  p = make_patch(0,0,0,1,3,0,'h17,1,6,15,15, 2, 3);
         5:  p = make_patch(0,1,0,0,1,0,'h00,0,0,15,15, 1, 3);
         6:  p = make_patch(0,0,1,0,3,2,'h1a,0,4,10, 3,15, 0);
         7:  p = make_patch(0,0,0,0,1,0,'h00,0,0,15, 4, 2, 3);
         8:  p = make_patch(0,0,0,1,1,0,'h0e,0,7,15,10, 7, 0);
         9:  p = make_patch(0,1,1,0,1,0,'h00,0,0, 6, 4, 1, 7);
         10: p = make_patch(0,0,1,0,2,0,'h1e,0,6,15, 0, 0, 0);
         11: p = make_patch(0,0,1,0,1,0,'h00,0,0, 7, 6, 2, 8);
         12: p = make_patch(0,0,1,0,1,0,'h16,0,5,15, 0, 0, 0);
         13: p = make_patch(0,0,1,0,2,0,'h00,0,0, 7, 1, 1, 8);
         14: p = make_patch(0,0,1,0,1,0,'h1d,0,7, 8, 2, 1, 0);
         15: p = make_patch(0,1,1,0,1,0,'h00,0,0, 8, 0, 0, 7);
         16: p = make_patch(0,0,1,0,3,0,'h2d,0,6, 9, 0, 0, 0);
         17: p = make_patch(0,0,1,0,1,0,'h00,1,0, 9, 0, 0, 7);
         18: p = make_patch(0,0,1,0,1,0,'h1b,0,6, 6, 4, 1, 0);
         19: p = make_patch(0,0,1,0,1,0,'h00,0,0, 6, 5, 1, 7);
         20: p = make_patch(0,0,1,0,1,0,'h0b,1,2, 8, 5, 7, 0);
         21: p = make_patch(0,0,1,0,1,0,'h00,1,0,10, 0, 0, 7);
         22: p = make_patch(0,0,1,0,3,2,'h02,0,0,15,15, 1, 0);
         23: p = make_patch(0,0,0,0,1,0,'h00,1,0,11, 0, 0, 4);
         24: p = make_patch(1,0,0,1,7,0,'h20,0,7,15,15, 2, 2);
         25: p = make_patch(1,1,0,0,1,0,'h00,0,0,15,15, 1, 2);
         26: p = make_patch(0,1,1,0,1,0,'h0c,0,5,13, 2, 4, 0);
         27: p = make_patch(0,0,0,0,0,0,'h00,0,0,15, 6, 4, 3);
         28: p = make_patch(0,0,0,0,1,1,'h16,0,3,15, 4, 0, 3);
         29: p = make_patch(0,0,0,0,1,0,'h00,0,0,15, 0, 0, 2);
         30: p = make_patch(0,0,1,0,1,2,'h09,0,3,15, 1,15, 0);
         31: p = make_patch(0,1,0,0,1,0,'h00,0,0,15, 4, 2, 3);
         32: p = make_patch(0,0,0,0,7,0,'h16,0,0,13,15,15,15);
         33: p = make_patch(0,0,1,0,1,0,'h00,0,0,15, 8,15, 8);
         34: p = make_patch(0,0,1,1,1,0,'h00,0,0,15, 7,15, 7);
         35: p = make_patch(0,0,1,1,2,0,'h00,0,0,15, 7,15, 7);
         36: p = make_patch(0,0,1,0,5,0,'h00,0,0,15, 8,15, 8);
         37: p = make_patch(0,0,0,0,1,0,'h00,0,0,13,12, 5, 5);
         default: p = '0;
      endcase
      return p;
   endfunction

   // user instrument from the eight patch bytes; carrier has no level or feedback
   function automatic patch_fields_type user_patch(bit carrier);
      patch_fields_type p;
      bit [7:0] c;
      p = '0;
      c = patch_bytes[carrier];
      p.am = c[7]; p.pm = c[6]; p.eg = c[5]; p.kr = c[4]; p.ml = c[3:0];
      if (carrier) begin
         p.kl = patch_bytes[3][7:6];
         p.wf = patch_bytes[3][4];
         {p.ar, p.dr} = patch_bytes[5];
         {p.sl, p.rr} = patch_bytes[7];
      end else begin
         p.kl = patch_bytes[2][7:6];
         p.tl = patch_bytes[2][5:0];
         p.wf = patch_bytes[3][3];
         p.fb = patch_bytes[3][2:0];
         {p.ar, p.dr} = patch_bytes[4];
         {p.sl, p.rr} = patch_bytes[6];
      end
      return p;
   endfunction

   // bus write: address latch or register update
   function automatic void apply_bus_write(bit port, bit [7:0] data);
      bit [5:0] r;
      bit [3:0] ch;
      if (port == PORT_ADDRESS) begin
         addr_latch = data;
         return;
      end
      r = addr_latch[5:0];
      if (r < USER_PATCH_COUNT) begin
         patch_bytes[r[2:0]] = data;
      end else if (r == fmrf_pkg::ADDR_RHYTHM) begin
         rhythm_reg = data;
      end else if (r[5:4] != GRP_PATCH) begin
         // channel addresses 9..f fold back onto channels 0..6
         ch = (r[3:0] >= 4'd9) ? r[3:0] - 4'd9 : r[3:0];
         case (r[5:4])
            fmrf_pkg::GRP_FREQ_LO: begin
               chan_freq[ch][7:0] = data;
            end
            fmrf_pkg::GRP_FREQ_HI: begin
               chan_freq[ch][11:8] = data[3:0];
               chan_key[ch] = data[4];
               chan_sus[ch] = data[5];
            end
            fmrf_pkg::GRP_INST_VOL: begin
               chan_inst[ch] = data[7:4];
               chan_vol[ch] = data[3:0];
            end
            default: ;
         endcase
      end
   endfunction

   // expected result of one slot query
   function automatic slot_level_type predict_slot_level(bit [4:0] slot);
      slot_level_type r;
      patch_fields_type p;
      bit [3:0] ch;
      bit rhythm;
      bit [8:0] fnum;
      bit [2:0] blk;
      bit [7:0] diff;
      bit [7:0] ksl;
      int level;
      r = '0;
      r.slot_echo = slot;
      if (slot >= fmrf_pkg::NUM_SLOTS) return r;
      ch = slot[4:1];
      rhythm = rhythm_reg[5];

      // patch selection: drums, user patch or built-in instrument
      if (rhythm && slot >= 12)
         p = fixed_patch(int'(slot) - 12 + 32);
      else if (chan_inst[ch] == 4'd0)
         p = user_patch(slot[0]);
      else
         p = fixed_patch(int'(chan_inst[ch]) * 2 + int'(slot[0]));

      // key scale, zero when the offset block pushes it negative
      fnum = chan_freq[ch][8:0];
      blk = chan_freq[ch][11:9];
      diff = 8'(int'(KSL_STEPS[fnum[8:5]]) - (7 - int'(blk)) * 8);
      ksl = {diff[6:0], 1'b0};
      if (ksl[7] || p.kl == 2'd0)
         ksl = '0;
      else
         ksl = ksl >> (3 - int'(p.kl));

      // base level: drum volume from instrument nibble, modulator tl, carrier volume
      if (rhythm && (slot == 14 || slot == 16))
         level = int'(chan_inst[ch]) * 8;
      else if (!slot[0])
         level = int'(p.tl) * 2;
      else
         level = int'(chan_vol[ch]) * 8;
      level += int'(ksl);
      if (level > 127) level = 127;

      r.total_level = 7'(level);
      r.freq_number = fnum;
      r.octave_block = blk;
      r.key_on = chan_key[ch];
      r.sustain_on = chan_sus[ch];
      r.rhythm_control = rhythm_reg[5:0];
      r.operator_params = p;
      return r;
   endfunction

   function automatic directed_row_type bus_row(bit port, bit [7:0] data);
      directed_row_type d;
      d = '0;
      d.word.func = FUNC_BUS_WRITE;
      d.word.port = port;
      d.word.data = data;
      return d;
   endfunction

   function automatic directed_row_type ask_row(bit [4:0] slot);
      directed_row_type d;
      d = '0;
      d.word.func = FUNC_SLOT_QUERY;
      d.word.slot_number = slot;
      return d;
   endfunction

   function automatic directed_row_type known_row(bit [4:0] slot, slot_level_type level);
      directed_row_type d;
      d = ask_row(slot);
      d.known = 1'b1;
      d.level = level;
      return d;
   endfunction

   // offer one word, wait for it to be taken, then update the predictor
   task automatic send_word(input req_word_type w, input bit known,
                            input slot_level_type level);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= w.func;
      req_port <= w.port;
      req_bus_data <= w.data;
      req_slot_number <= w.slot_number;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      if (w.func == FUNC_SLOT_QUERY)
         pending_levels.push_back(known ? level : predict_slot_level(w.slot_number));
      else
         apply_bus_write(w.port, w.data);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      slot_level_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_levels.size() == 0) begin
            $error("result word for slot %0d with nothing outstanding", rsp_slot_echo);
            mismatch_count++;
         end else begin
            want = pending_levels.pop_front();
            check_field("slot_echo", want.slot_echo, rsp_slot_echo);
            check_field("total_level", want.total_level, rsp_total_level);
            check_field("freq_number", want.freq_number, rsp_freq_number);
            check_field("octave_block", want.octave_block, rsp_octave_block);
            check_field("key_on", want.key_on, rsp_key_on);
            check_field("sustain_on", want.sustain_on, rsp_sustain_on);
            check_field("rhythm_control", want.rhythm_control, rsp_rhythm_control);
            check_field("operator_params", want.operator_params, rsp_operator_params);
         end
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      directed_row_type directed_rows [25];
      req_word_type w;
      int phase;
      int sent;
      int kind;
      int guard;

      // after reset, out-of-range slots, saturation, aliasing, drums, unused address
      directed_rows = '{
         known_row(5'd0, {5'd0, 63'd0}),
         known_row(5'd17, {5'd17, 63'd0}),
         known_row(5'd31, {5'd31, 63'd0}),
         known_row(5'd18, {5'd18, 63'd0}),
         bus_row(PORT_ADDRESS, 8'hc0),
         bus_row(PORT_DATA, 8'hff),
         bus_row(PORT_ADDRESS, 8'h02),
         bus_row(PORT_DATA, 8'hff),
         bus_row(PORT_ADDRESS, 8'h10),
         bus_row(PORT_DATA, 8'hff),
         bus_row(PORT_ADDRESS, 8'h20),
         bus_row(PORT_DATA, 8'hff),
         // full tl plus full key scale clips at 127
         known_row(5'd0, {5'd0, 7'd127, 9'h1ff, 3'd7, 1'b1, 1'b1, 6'd0, 36'hffff00000}),
         ask_row(5'd1),
         bus_row(PORT_ADDRESS, 8'h39),
         bus_row(PORT_DATA, 8'hff),
         ask_row(5'd1),
         bus_row(PORT_ADDRESS, 8'h0e),
         bus_row(PORT_DATA, 8'h3f),
         ask_row(5'd14),
         ask_row(5'd16),
         ask_row(5'd12),
         bus_row(PORT_ADDRESS, 8'h0f),
         bus_row(PORT_DATA, 8'h00),
         ask_row(5'd17)
      };

      sender_idle_pct = 32;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].level);

      // random part: register write pairs, queries, stray bus words
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 79 : 0;
         sent = 0;
         while (sent < PHASE_WORDS) begin
            kind = $urandom_range(0, 99);
            w.slot_number = 5'($urandom_range(0, 31));
            if (kind < 45) begin
               w.func = FUNC_BUS_WRITE;
               w.port = PORT_ADDRESS;
               case ($urandom_range(0, 5))
                  0: w.data = 8'($urandom_range(0, 7));
                  1: w.data = 8'(fmrf_pkg::ADDR_RHYTHM);
                  2: w.data = 8'h10 + 8'($urandom_range(0, 15));
                  3: w.data = 8'h20 + 8'($urandom_range(0, 15));
                  4: w.data = 8'h30 + 8'($urandom_range(0, 15));
                  default: w.data = 8'($urandom_range(0, 255));
               endcase
               // upper address bits are kept but ignored by the decode
               w.data[7:6] = 2'($urandom_range(0, 3));
               send_word(w, 1'b0, '0);
               w.port = PORT_DATA;
               w.data = 8'($urandom_range(0, 255));
               w.slot_number = 5'($urandom_range(0, 31));
               send_word(w, 1'b0, '0);
               sent += 2;
            end else if (kind < 92) begin
               w.func = FUNC_SLOT_QUERY;
               w.port = 1'($urandom_range(0, 1));
               w.data = 8'($urandom_range(0, 255));
               w.slot_number = (kind < 85) ? 5'($urandom_range(0, 17))
                                           : 5'($urandom_range(18, 31));
               send_word(w, 1'b0, '0);
               sent++;
            end else begin
               w.func = FUNC_BUS_WRITE;
               w.port = 1'($urandom_range(0, 1));
               w.data = 8'($urandom_range(0, 255));
               send_word(w, 1'b0, '0);
               sent++;
            end
         end
         // after the first phase only, hold off until every outstanding result has come back
         if (phase == 0) begin
            start <= 1'b0;
            do @(posedge clock); while (pending_levels.size() != 0);
         end
      end

      // drain
      start <= 1'b0;
      for (guard = 0; guard < DRAIN_CYCLES && pending_levels.size() != 0; guard++)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (pending_levels.size() != 0) begin
         $error("%0d results never arrived", pending_levels.size());
         mismatch_count++;
      end

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fmrf_pkg.sv
rtl/core/fmrf_chan_ram.sv
rtl/core/fmrf_level.sv
rtl/core/fm_synth_register_file_level.sv
tb/sv/tb_fm_synth_register_file_level.sv
